// ===== hw/rtl/epo_pkg.sv =====
// ---------------------------------------------------------------------------
// epo_pkg
// types and constants shared by the projection fit filter and its divider
// ---------------------------------------------------------------------------
package epo_pkg;

	localparam int MaxColumns = 256;
	localparam int MaxRows    = 4096;
	localparam int ColBits    = 8;
	localparam int RowBits    = 13;

	localparam logic [1:0] OP_FIT    = 2'd0;
	localparam logic [1:0] OP_FILTER = 2'd1;
	localparam logic [1:0] OP_PASS   = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FEW_ROWS = 2'd1;
	localparam logic [1:0] ST_ZERO_VAR = 2'd2;
	localparam logic [1:0] ST_UNFIT    = 2'd3;

	localparam logic [0:0] REG_COLUMN_COUNT  = 1'b0;
	localparam logic [0:0] REG_CENTER_ENABLE = 1'b1;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [15:0] sample_value;
		logic signed [15:0] parameter_value;
		logic               last_element;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] filtered_value;
		logic [1:0]         status;
	} out_item_t;

	// request from the control to the divider
	typedef struct packed {
		logic               start;
		logic signed [63:0] num;
		logic [63:0]        den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quot;
	} div_rsp_t;

endpackage

// ===== hw/rtl/epo_div.sv =====
// ---------------------------------------------------------------------------
// epo_div
// restoring divider, one quotient bit per cycle: num*2^16/den, saturated q16
// ---------------------------------------------------------------------------
module epo_div (
	input  logic              clk,
	input  logic              arst_n,
	input  epo_pkg::div_req_t req,
	output epo_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic [63:0] mag_q;
	logic [63:0] den_q;
	logic [64:0] rem_q;
	logic [79:0] quo_q;
	logic [64:0] rem_sh;
	logic [63:0] mag_abs;
	logic        bit_in;
	logic        done_q;
	logic [31:0] res;

	assign mag_abs = req.num[63] ? (64'd0 - req.num) : req.num;
	// dividend is mag<<16, fed msb first over 80 steps
	assign bit_in  = (cnt_q >= 7'd16) ? mag_q[6'(cnt_q - 7'd16)] : 1'b0;
	assign rem_sh  = {rem_q[63:0], bit_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd79;
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[63];
			mag_q <= mag_abs;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[78:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[78:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (quo_q[79:31] != '0) begin
			res = 32'h8000_0000;
		end else begin
			res = quo_q[31:0];
		end
		if (neg_q) begin
			rsp.quot = (res[31]) ? 32'sh8000_0000 : -$signed(res);
		end else begin
			rsp.quot = res[31] ? 32'sh7FFF_FFFF : $signed(res);
		end
		rsp.done = done_q;
	end

endmodule

// ===== hw/rtl/epo_projection_fit_filter.sv =====
// ---------------------------------------------------------------------------
// epo_projection_fit_filter
// streaming fit of per-column projection coefficients and filter
// ---------------------------------------------------------------------------
// a filter or pass-through item passes S_RD, S_EXEC, S_MUL and S_OUT, and its result is
// registered; items are taken only in S_IDLE, so each is done before the next is taken;
// sums, cross sums and coefficients live in synchronous memories with registered reads;
// with fit status OK, fit end walks each column through S_FC0 to S_FC3 and the divider;
// reset clears control state; a clearing pass over all 256 sum memory entries runs after
// reset and after every fit end, with no items taken meanwhile
module epo_projection_fit_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  epo_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output epo_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [8:0]          cfg_data
);

	localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_EXEC = 4'd3,
		S_MUL = 4'd4, S_OUT = 4'd5, S_F0 = 4'd6, S_F1 = 4'd7, S_F2 = 4'd8,
		S_FC0 = 4'd9, S_FC1 = 4'd10, S_FC2 = 4'd11, S_FC3 = 4'd12, S_FDIV = 4'd13,
		S_FMEAN = 4'd14, S_FMW = 4'd15;

	logic [3:0] st_q;

	// memories
	logic [27:0] sum_mem [epo_pkg::MaxColumns];
	logic [43:0] xsum_mem [epo_pkg::MaxColumns];
	logic [31:0] coef_mem [epo_pkg::MaxColumns];
	logic [7:0]  addr;
	logic        sum_we, coef_we;
	logic [27:0] sum_wd, sum_rd;
	logic [43:0] xsum_wd, xsum_rd;
	logic [31:0] coef_wd, coef_rd;

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[addr]  <= sum_wd;
			xsum_mem[addr] <= xsum_wd;
		end
		sum_rd  <= sum_mem[addr];
		xsum_rd <= xsum_mem[addr];
		if (coef_we) begin
			coef_mem[addr] <= coef_wd;
		end
		coef_rd <= coef_mem[addr];
	end

	logic [8:0]  ccount_q;
	logic        center_q;
	logic [7:0]  col_q, fcol_q;
	logic [8:0]  cols;
	logic [27:0] psum_q;
	logic [42:0] psq_q;
	logic [12:0] rows_q;
	logic        drop_q, fitted_q;
	logic signed [31:0] mean_q;
	epo_pkg::in_item_t item_q;
	logic signed [63:0] prod_q, den_q, num_q, a_q;
	logic [63:0]  t_q;
	logic        ovalid_q;
	epo_pkg::out_item_t odata_q;
	logic [1:0]  fstat_q;
	epo_pkg::div_req_t dreq;
	epo_pkg::div_rsp_t drsp;

	epo_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign cols = (ccount_q == 9'd0) ? 9'd1 :
		(ccount_q > 9'(epo_pkg::MaxColumns)) ? 9'(epo_pkg::MaxColumns) : ccount_q;

	assign in_stall  = (st_q != S_IDLE) || (ovalid_q && out_stall);
	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	logic signed [63:0] n64, sx, xx, ps;
	logic signed [16:0] xs17;
	logic signed [31:0] xd;
	logic signed [47:0] dsh;
	logic signed [48:0] dc;
	logic [48:0] dm;
	logic [31:0] bm;
	logic [80:0] mprod;
	logic signed [63:0] fv;
	logic signed [23:0] sat;
	logic        sneg;

	assign n64 = 64'(rows_q);
	assign sx  = 64'(signed'(sum_rd));
	assign xx  = 64'(signed'(xsum_rd));
	assign ps  = 64'(signed'(psum_q));
	assign xd  = item_q.sample_value * item_q.parameter_value;
	assign dsh = 48'(signed'(item_q.parameter_value)) <<< 16;
	assign dc  = 49'(dsh) - 49'(mean_q);
	assign dm  = dc[48] ? 49'(-dc) : 49'(dc);
	assign bm  = coef_rd[31] ? (32'd0 - coef_rd) : coef_rd;
	assign sneg = dc[48] ^ coef_rd[31];
	assign mprod = 81'(dm) * 81'(bm);
	// t_q holds the signed projection term
	assign fv = 64'(item_q.sample_value) - signed'(t_q);
	assign sat = (fv > 64'sd8388607) ? 24'sh7FFFFF :
		(fv < -64'sd8388608) ? 24'sh800000 : fv[23:0];
	assign xs17 = 17'(item_q.sample_value);

	always_comb begin
		addr    = col_q;
		sum_we  = 1'b0;
		coef_we = 1'b0;
		sum_wd  = sum_rd + 28'(signed'(item_q.sample_value));
		xsum_wd = xsum_rd + 44'(xd);
		coef_wd = drsp.quot;
		dreq    = '0;
		case (st_q)
			S_CLEAR: begin
				addr = fcol_q; sum_we = 1'b1; sum_wd = '0; xsum_wd = '0;
			end
			S_EXEC: begin
				sum_we = (item_q.opcode == epo_pkg::OP_FIT) && !((col_q == 8'd0) ?
					(rows_q >= 13'(epo_pkg::MaxRows)) : drop_q);
			end
			S_FC0, S_FC1, S_FC2, S_FC3, S_FDIV: begin
				addr = fcol_q;
				coef_we = (st_q == S_FDIV) && drsp.done;
			end
			default: ;
		endcase
		if (st_q == S_FC3) begin
			dreq.start = 1'b1; dreq.num = num_q; dreq.den = den_q;
		end
		if (st_q == S_FMEAN) begin
			dreq.start = 1'b1; dreq.num = ps; dreq.den = n64;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR; fcol_q <= '0; col_q <= '0; ccount_q <= 9'd1;
			center_q <= 1'b1; psum_q <= '0; psq_q <= '0; rows_q <= '0;
			drop_q <= 1'b0; fitted_q <= 1'b0; mean_q <= '0; ovalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					epo_pkg::REG_COLUMN_COUNT:  ccount_q <= cfg_data;
					epo_pkg::REG_CENTER_ENABLE: center_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			case (st_q)
				S_CLEAR: begin
					fcol_q <= fcol_q + 8'd1;
					if (fcol_q == 8'hFF) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						item_q <= in_data;
						st_q   <= (in_data.opcode == epo_pkg::OP_NONE) ? S_IDLE : S_RD;
					end
				end
				S_RD: st_q <= S_EXEC;
				S_EXEC: begin
					col_q <= (9'(col_q) + 9'd1 >= cols) ? 8'd0 : col_q + 8'd1;
					if (item_q.opcode == epo_pkg::OP_FIT) begin
						if (col_q == 8'd0) begin
							drop_q <= rows_q >= 13'(epo_pkg::MaxRows);
							if (rows_q < 13'(epo_pkg::MaxRows)) begin
								rows_q <= rows_q + 13'd1;
								psum_q <= psum_q + 28'(signed'(item_q.parameter_value));
								psq_q  <= psq_q + 43'(item_q.parameter_value *
									item_q.parameter_value);
							end
						end
						st_q <= item_q.last_element ? S_F0 : S_IDLE;
					end else begin
						t_q  <= sneg ? (64'd0 - 64'(mprod[80:32])) : 64'(mprod[80:32]);
						st_q <= S_MUL;
					end
				end
				S_MUL: st_q <= S_OUT;
				S_OUT: begin
					ovalid_q <= 1'b1;
					if (!fitted_q) begin
						odata_q <= '{filtered_value: '0, status: epo_pkg::ST_UNFIT};
					end else if (item_q.opcode == epo_pkg::OP_PASS) begin
						odata_q <= '{filtered_value: 24'(xs17), status: epo_pkg::ST_OK};
					end else begin
						odata_q <= '{filtered_value: sat, status: epo_pkg::ST_OK};
					end
					st_q <= S_IDLE;
				end
				S_F0: begin
					prod_q <= n64 * signed'(64'(psq_q));
					st_q   <= S_F1;
				end
				S_F1: begin
					a_q  <= ps * ps;
					st_q <= S_F2;
				end
				S_F2: begin
					den_q  <= center_q ? (prod_q - a_q) : signed'(64'(psq_q));
					fcol_q <= '0;
					col_q  <= '0;
					if (rows_q < 13'd2) begin
						fstat_q <= epo_pkg::ST_FEW_ROWS; st_q <= S_FMW;
					end else if ((center_q ? (prod_q - a_q) : signed'(64'(psq_q)))
						<= 64'sd0) begin
						fstat_q <= epo_pkg::ST_ZERO_VAR; st_q <= S_FMW;
					end else begin
						fstat_q <= epo_pkg::ST_OK; st_q <= S_FC0;
					end
				end
				S_FC0: st_q <= S_FC1;
				S_FC1: begin
					prod_q <= n64 * xx;
					a_q    <= sx * ps;
					st_q   <= S_FC2;
				end
				S_FC2: begin
					num_q <= center_q ? (prod_q - a_q) : xx;
					st_q  <= S_FC3;
				end
				S_FC3: st_q <= S_FDIV;
				S_FDIV: begin
					if (drsp.done) begin
						if (9'(fcol_q) + 9'd1 >= cols) begin
							st_q <= center_q ? S_FMEAN : S_FMW;
							if (!center_q) mean_q <= '0;
						end else begin
							fcol_q <= fcol_q + 8'd1;
							st_q   <= S_FC0;
						end
					end
				end
				S_FMEAN: begin
					fcol_q <= '1;
					st_q   <= S_FMW;
				end
				S_FMW: begin
					if (fstat_q == epo_pkg::ST_OK && center_q && fcol_q == 8'hFF) begin
						if (drsp.done) begin
							mean_q <= drsp.quot; fcol_q <= '0;
						end
					end else if (!ovalid_q) begin
						if (fstat_q == epo_pkg::ST_OK) fitted_q <= 1'b1;
						ovalid_q <= 1'b1;
						odata_q  <= '{filtered_value: '0, status: fstat_q};
						psum_q <= '0; psq_q <= '0; rows_q <= '0; drop_q <= 1'b0;
						col_q <= '0; fcol_q <= '0;
						st_q <= S_CLEAR;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule
